// ===== hdl/lssa_pkg.sv =====
package lssa_pkg;

	// Fixed geometry of the allocator.
	localparam int MAX_SEGMENTS      = 64;
	localparam int HEADER_BYTES      = 20;
	// Object sizes are rounded up to this granule, which must be a power of two.
	localparam int ALIGN_BYTES       = 4;
	localparam int MAX_SEGMENT_BYTES = 1048576;

	// Field widths of the channels.
	localparam int KEY_W    = 8;
	localparam int VALUE_W  = 21;
	localparam int OBJ_W    = 22;
	localparam int OBJOUT_W = 21;
	localparam int IDX_W    = 6;
	localparam int OFF_W    = 20;
	localparam int CAP_W    = 21;
	localparam int CFG_W    = 21;
	localparam int CFGIDX_W = 2;

	localparam logic [CAP_W-1:0] SEGMENT_BYTES_RESET = 21'd1048576;
	localparam logic [6:0]       SEGMENT_COUNT_RESET = 7'd64;

	typedef enum logic [CFGIDX_W-1:0] {
		REG_SEGMENT_BYTES = 2'd0,
		REG_SEGMENT_COUNT = 2'd1
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_STORED    = 2'd0,
		ST_TOO_LARGE = 2'd1,
		ST_NO_SPACE  = 2'd2
	} status_t;

	// Placement outcome handed from the placement unit to the result register.
	typedef struct packed {
		status_t           status;
		logic [IDX_W-1:0]  segment_index;
		logic [OFF_W-1:0]  byte_offset;
		logic              evicted;
		logic [IDX_W-1:0]  evicted_segment;
	} place_result_t;

endpackage

// ===== hdl/log_segment_space_allocator_core.sv =====
// Log-structured segment ring allocator.
//
// A request transaction on the input channel (in_valid/in_ready) carries the
// key and value lengths of one object. Each request yields exactly one result
// transaction on the output channel (out_valid/out_ready): a status, the
// segment and byte offset where the object was placed, its aligned size with
// header, and whether the oldest segment was evicted to make room.
//
// The object size is computed and registered in the input stage on acceptance;
// the placement against the ring state is decided and registered in the result
// register, together with the ring state (head, tail, write offset), when the
// input stage advances: one request per cycle while the receiver keeps up.
// If the receiver stalls, the result register holds its transaction and one
// further request waits in the input stage; in_ready falls only when both
// are full.
//
// Reset empties the ring and sets the segment size to 1 MiB and the segment
// count to 64. A write to either configuration register also empties the
// ring; writes are expected only while no request is in flight.
module log_segment_space_allocator_core #(
	parameter int MAX_SEGMENTS = lssa_pkg::MAX_SEGMENTS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lssa_pkg::CFGIDX_W-1:0]      cfg_index,
	input  logic [lssa_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [lssa_pkg::KEY_W-1:0]         key_length,
	input  logic [lssa_pkg::VALUE_W-1:0]       value_length,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         status,
	output logic [lssa_pkg::IDX_W-1:0]         segment_index,
	output logic [lssa_pkg::OFF_W-1:0]         byte_offset,
	output logic [lssa_pkg::OBJOUT_W-1:0]      object_bytes,
	output logic                               evicted,
	output logic [lssa_pkg::IDX_W-1:0]         evicted_segment
);

	localparam int N_W = $clog2(MAX_SEGMENTS + 1);

	// Configuration registers.
	logic [lssa_pkg::CAP_W-1:0]      seg_bytes_q;
	logic [6:0]                      seg_count_q;
	logic [lssa_pkg::CAP_W-1:0]      capacity;
	logic [N_W-1:0]                  ring_n;
	logic                            cfg_clear;

	// Input stage and result register.
	logic                            valid_s1;
	logic [lssa_pkg::OBJ_W-1:0]      obj_s1;
	logic [lssa_pkg::OBJOUT_W-1:0]   obj_sat_s1;
	logic                            out_valid_q;
	lssa_pkg::place_result_t         result_q;
	logic [lssa_pkg::OBJOUT_W-1:0]   obj_sat_q;

	logic [lssa_pkg::OBJ_W-1:0]      obj_bytes;
	logic [lssa_pkg::OBJOUT_W-1:0]   obj_bytes_sat;
	lssa_pkg::place_result_t         place_result;
	logic                            in_accept;
	logic                            advance;

	// A write to either register restarts the ring from segment zero.
	assign cfg_clear = cfg_we && (cfg_index == lssa_pkg::REG_SEGMENT_BYTES
		|| cfg_index == lssa_pkg::REG_SEGMENT_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_bytes_q <= lssa_pkg::SEGMENT_BYTES_RESET;
			seg_count_q <= lssa_pkg::SEGMENT_COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lssa_pkg::REG_SEGMENT_BYTES: begin
					seg_bytes_q <= cfg_data;
				end
				lssa_pkg::REG_SEGMENT_COUNT: begin
					seg_count_q <= cfg_data[6:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Effective capacity and ring size: out-of-range values are clamped.
	always_comb begin
		if (32'(seg_bytes_q) > 32'(lssa_pkg::MAX_SEGMENT_BYTES)) begin
			capacity = lssa_pkg::CAP_W'(lssa_pkg::MAX_SEGMENT_BYTES);
		end else begin
			capacity = seg_bytes_q;
		end
		if (seg_count_q == 7'd0) begin
			ring_n = N_W'(1);
		end else if (32'(seg_count_q) > 32'(MAX_SEGMENTS)) begin
			ring_n = N_W'(MAX_SEGMENTS);
		end else begin
			ring_n = N_W'(seg_count_q);
		end
	end

	// The input stage moves on whenever the result register is free or being
	// emptied in the same cycle.
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign in_accept = in_valid && in_ready;

	lssa_size u_size (
		.key_length    (key_length),
		.value_length  (value_length),
		.obj_bytes     (obj_bytes),
		.obj_bytes_sat (obj_bytes_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			obj_s1     <= obj_bytes;
			obj_sat_s1 <= obj_bytes_sat;
		end
	end

	lssa_place #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_place (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (cfg_clear),
		.update    (advance),
		.obj_bytes (obj_s1),
		.capacity  (capacity),
		.ring_n    (ring_n),
		.result    (place_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q  <= place_result;
			obj_sat_q <= obj_sat_s1;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = result_q.status;
	assign segment_index   = result_q.segment_index;
	assign byte_offset     = result_q.byte_offset;
	assign object_bytes    = obj_sat_q;
	assign evicted         = result_q.evicted;
	assign evicted_segment = result_q.evicted_segment;

	// An eviction always comes with a placement at the start of a segment.
	a_evict_stores: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.evicted) |->
			(result_q.status == lssa_pkg::ST_STORED && result_q.byte_offset == '0))
		else $error("eviction reported without a fresh placement");

	// A rejected request leaves placement fields at zero.
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.status != lssa_pkg::ST_STORED) |->
			(result_q.segment_index == '0 && result_q.byte_offset == '0
			&& !result_q.evicted))
		else $error("rejected request carries placement fields");

	// A request that leaves the input stage shows up as a result next cycle.
	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced request lost before the result register");

	// An accepted request is held in the input stage.
	a_accept_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> valid_s1)
		else $error("accepted request not held in the input stage");

endmodule

// ===== hdl/lssa_size.sv =====
module lssa_size (
	input  logic [lssa_pkg::KEY_W-1:0]    key_length,
	input  logic [lssa_pkg::VALUE_W-1:0]  value_length,
	output logic [lssa_pkg::OBJ_W-1:0]    obj_bytes,
	output logic [lssa_pkg::OBJOUT_W-1:0] obj_bytes_sat
);

	localparam logic [lssa_pkg::OBJ_W-1:0] ALIGN_MASK =
		lssa_pkg::OBJ_W'(lssa_pkg::ALIGN_BYTES - 1);

	logic [lssa_pkg::OBJ_W-1:0] raw_bytes;

	always_comb begin
		raw_bytes = lssa_pkg::OBJ_W'(lssa_pkg::HEADER_BYTES)
			+ lssa_pkg::OBJ_W'(key_length)
			+ lssa_pkg::OBJ_W'(value_length);
		obj_bytes = (raw_bytes + ALIGN_MASK) & ~ALIGN_MASK;
		// The reported size saturates when the true size does not fit its field.
		if (obj_bytes > lssa_pkg::OBJ_W'({lssa_pkg::OBJOUT_W{1'b1}})) begin
			obj_bytes_sat = {lssa_pkg::OBJOUT_W{1'b1}};
		end else begin
			obj_bytes_sat = obj_bytes[lssa_pkg::OBJOUT_W-1:0];
		end
	end

endmodule

// ===== hdl/lssa_place.sv =====
module lssa_place #(
	parameter int MAX_SEGMENTS = lssa_pkg::MAX_SEGMENTS
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       clear,
	input  logic                                       update,
	input  logic [lssa_pkg::OBJ_W-1:0]                 obj_bytes,
	input  logic [lssa_pkg::CAP_W-1:0]                 capacity,
	input  logic [$clog2(MAX_SEGMENTS+1)-1:0]          ring_n,
	output lssa_pkg::place_result_t                    result
);

	localparam int SEG_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int N_W   = $clog2(MAX_SEGMENTS + 1);

	logic [SEG_W-1:0]                head_q;
	logic [SEG_W-1:0]                tail_q;
	logic [lssa_pkg::CAP_W-1:0]      offset_q;

	logic [SEG_W-1:0]                head_d;
	logic [SEG_W-1:0]                tail_d;
	logic [lssa_pkg::CAP_W-1:0]      offset_d;
	logic [SEG_W-1:0]                head_nx;
	logic [SEG_W-1:0]                tail_nx;
	logic [N_W-1:0]                  head_inc;
	logic [N_W-1:0]                  tail_inc;
	logic [lssa_pkg::CAP_W-1:0]      room;

	always_comb begin
		head_inc = N_W'(head_q) + N_W'(1);
		tail_inc = N_W'(tail_q) + N_W'(1);
		head_nx  = (head_inc >= ring_n) ? '0 : SEG_W'(head_inc);
		tail_nx  = (tail_inc >= ring_n) ? '0 : SEG_W'(tail_inc);
		room     = (offset_q <= capacity) ? capacity - offset_q : '0;

		head_d   = head_q;
		tail_d   = tail_q;
		offset_d = offset_q;
		result.status          = lssa_pkg::ST_STORED;
		result.segment_index   = '0;
		result.byte_offset     = '0;
		result.evicted         = 1'b0;
		result.evicted_segment = '0;

		if (obj_bytes > {1'b0, capacity}) begin
			result.status = lssa_pkg::ST_TOO_LARGE;
		end else if ({1'b0, room} >= obj_bytes) begin
			result.segment_index = lssa_pkg::IDX_W'(tail_q);
			result.byte_offset   = offset_q[lssa_pkg::OFF_W-1:0];
			offset_d             = offset_q + obj_bytes[lssa_pkg::CAP_W-1:0];
		end else if (tail_nx != head_q) begin
			tail_d               = tail_nx;
			offset_d             = obj_bytes[lssa_pkg::CAP_W-1:0];
			result.segment_index = lssa_pkg::IDX_W'(tail_nx);
		end else if (head_q == tail_q) begin
			result.status = lssa_pkg::ST_NO_SPACE;
		end else begin
			// Ring full: the oldest segment is dropped to make room.
			head_d                 = head_nx;
			tail_d                 = tail_nx;
			offset_d               = obj_bytes[lssa_pkg::CAP_W-1:0];
			result.segment_index   = lssa_pkg::IDX_W'(tail_nx);
			result.evicted         = 1'b1;
			result.evicted_segment = lssa_pkg::IDX_W'(head_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			offset_q <= '0;
		end else if (clear) begin
			head_q   <= '0;
			tail_q   <= '0;
			offset_q <= '0;
		end else if (update) begin
			head_q   <= head_d;
			tail_q   <= tail_d;
			offset_q <= offset_d;
		end
	end

endmodule

// ===== tb/sv/log_segment_space_allocator_core_checker.sv =====
module log_segment_space_allocator_core_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lssa_pkg::CFGIDX_W-1:0]     cfg_index,
	input  logic [lssa_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [lssa_pkg::KEY_W-1:0]        key_length,
	input  logic [lssa_pkg::VALUE_W-1:0]      value_length,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [1:0]                        status,
	input  logic [lssa_pkg::IDX_W-1:0]        segment_index,
	input  logic [lssa_pkg::OFF_W-1:0]        byte_offset,
	input  logic [lssa_pkg::OBJOUT_W-1:0]     object_bytes,
	input  logic                              evicted,
	input  logic [lssa_pkg::IDX_W-1:0]        evicted_segment,
	output int                                failures,
	output int                                pending,
	output int                                placed,
	output int                                oversized,
	output int                                refused,
	output int                                evictions
);

	typedef struct packed {
		lssa_pkg::status_t              status;
		logic [lssa_pkg::IDX_W-1:0]     segment_index;
		logic [lssa_pkg::OFF_W-1:0]     byte_offset;
		logic [lssa_pkg::OBJOUT_W-1:0]  object_bytes;
		logic                           evicted;
		logic [lssa_pkg::IDX_W-1:0]     evicted_segment;
	} placement_t;

	// Shadow copy of the registers and the ring.
	logic [lssa_pkg::CAP_W-1:0] seg_bytes;
	logic [6:0]                 seg_count;
	int                         ring_head;
	int                         ring_tail;
	int                         tail_fill;
	placement_t                 placements_due[$];

	task automatic report_mismatch(input string msg);
		failures++;
		$display("[%0t] allocator mismatch: %s", $time, msg);
	endtask

	// Works out where the object lands and advances the shadow ring.
	function automatic placement_t place_object(input logic [lssa_pkg::KEY_W-1:0] key,
	                                            input logic [lssa_pkg::VALUE_W-1:0] value);
		placement_t res;
		int obj;
		int cap;
		int n;
		int room;
		int nxt;
		obj = (lssa_pkg::HEADER_BYTES + int'(key) + int'(value) + lssa_pkg::ALIGN_BYTES - 1)
		      / lssa_pkg::ALIGN_BYTES * lssa_pkg::ALIGN_BYTES;
		cap = (seg_bytes > lssa_pkg::MAX_SEGMENT_BYTES) ?
			lssa_pkg::MAX_SEGMENT_BYTES : int'(seg_bytes);
		n = (seg_count == 0) ? 1 : (seg_count > lssa_pkg::MAX_SEGMENTS) ?
			lssa_pkg::MAX_SEGMENTS : int'(seg_count);
		res = '0;
		res.status = lssa_pkg::ST_STORED;
		res.object_bytes = (obj > 2 ** lssa_pkg::OBJOUT_W - 1) ? '1 :
			lssa_pkg::OBJOUT_W'(obj);
		nxt = (ring_tail + 1 >= n) ? 0 : ring_tail + 1;
		if (obj > cap) begin
			res.status = lssa_pkg::ST_TOO_LARGE;
		end else begin
			room = (tail_fill <= cap) ? cap - tail_fill : 0;
			if (room >= obj) begin
				res.segment_index = lssa_pkg::IDX_W'(ring_tail);
				res.byte_offset = lssa_pkg::OFF_W'(tail_fill);
				tail_fill += obj;
			end else if (nxt != ring_head) begin
				ring_tail = nxt;
				res.segment_index = lssa_pkg::IDX_W'(nxt);
				tail_fill = obj;
			end else if (ring_head == ring_tail) begin
				res.status = lssa_pkg::ST_NO_SPACE;
			end else begin
				res.evicted = 1'b1;
				res.evicted_segment = lssa_pkg::IDX_W'(ring_head);
				ring_head = (ring_head + 1 >= n) ? 0 : ring_head + 1;
				ring_tail = nxt;
				res.segment_index = lssa_pkg::IDX_W'(nxt);
				tail_fill = obj;
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		placement_t exp;
		if (!arst_n) begin
			seg_bytes = lssa_pkg::SEGMENT_BYTES_RESET;
			seg_count = lssa_pkg::SEGMENT_COUNT_RESET;
			ring_head = 0;
			ring_tail = 0;
			tail_fill = 0;
			placements_due.delete();
			pending = 0;
		end else begin
			// Results are retired before new requests are queued, so an unexpected
			// result can never pair up with a request accepted at the same edge.
			if (out_valid && out_ready) begin
				if (placements_due.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected (status %0d)", status));
				end else begin
					exp = placements_due.pop_front();
					if (status != exp.status)
						report_mismatch($sformatf("status %0d, expected %0d", status, exp.status));
					if (segment_index != exp.segment_index)
						report_mismatch($sformatf("segment_index %0d, expected %0d",
							segment_index, exp.segment_index));
					if (byte_offset != exp.byte_offset)
						report_mismatch($sformatf("byte_offset %0d, expected %0d",
							byte_offset, exp.byte_offset));
					if (object_bytes != exp.object_bytes)
						report_mismatch($sformatf("object_bytes %0d, expected %0d",
							object_bytes, exp.object_bytes));
					if (evicted != exp.evicted)
						report_mismatch($sformatf("evicted %0d, expected %0d", evicted, exp.evicted));
					if (evicted_segment != exp.evicted_segment)
						report_mismatch($sformatf("evicted_segment %0d, expected %0d",
							evicted_segment, exp.evicted_segment));
					case (exp.status)
						lssa_pkg::ST_STORED:    placed++;
						lssa_pkg::ST_TOO_LARGE: oversized++;
						default:                refused++;
					endcase
					if (exp.evicted)
						evictions++;
				end
			end
			if (cfg_we) begin
				if (cfg_index == lssa_pkg::REG_SEGMENT_BYTES) begin
					seg_bytes = cfg_data;
					ring_head = 0;
					ring_tail = 0;
					tail_fill = 0;
				end else if (cfg_index == lssa_pkg::REG_SEGMENT_COUNT) begin
					seg_count = cfg_data[6:0];
					ring_head = 0;
					ring_tail = 0;
					tail_fill = 0;
				end
			end
			if (in_valid && in_ready)
				placements_due.push_back(place_object(key_length, value_length));
			pending = placements_due.size();
		end
	end

endmodule

// ===== tb/sv/log_segment_space_allocator_core_tb.sv =====
// Stimulus and verdict for the segment ring allocator. A separate checker
// watches both channels and the register port, keeps its own copy of the
// ring, and counts every disagreement; this module only drives the block
// and decides the outcome of the run.
module log_segment_space_allocator_core_tb;

	// Generous bound on the whole run, far beyond the slowest legal schedule.
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 150;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [lssa_pkg::CFGIDX_W-1:0]  cfg_index;
	logic [lssa_pkg::CFG_W-1:0]     cfg_data;
	logic                           in_valid;
	logic                           in_ready;
	logic [lssa_pkg::KEY_W-1:0]     key_length;
	logic [lssa_pkg::VALUE_W-1:0]   value_length;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [1:0]                     status;
	logic [lssa_pkg::IDX_W-1:0]     segment_index;
	logic [lssa_pkg::OFF_W-1:0]     byte_offset;
	logic [lssa_pkg::OBJOUT_W-1:0]  object_bytes;
	logic                           evicted;
	logic [lssa_pkg::IDX_W-1:0]     evicted_segment;

	int failures;
	int pending;
	int placed;
	int oversized;
	int refused;
	int evictions;

	// Percentages of cycles in which the sender idles and the receiver stalls.
	int tx_idle_pct;
	int rx_stall_pct;
	int requests_sent;
	int settings_applied;
	int cycle_count;
	// The capacity that the currently programmed segment size gives, used only
	// to steer the random object sizes towards interesting boundaries.
	int capacity;

	always #6 clk = ~clk;

	log_segment_space_allocator_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.key_length     (key_length),
		.value_length   (value_length),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.segment_index  (segment_index),
		.byte_offset    (byte_offset),
		.object_bytes   (object_bytes),
		.evicted        (evicted),
		.evicted_segment(evicted_segment)
	);

	log_segment_space_allocator_core_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.key_length     (key_length),
		.value_length   (value_length),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.segment_index  (segment_index),
		.byte_offset    (byte_offset),
		.object_bytes   (object_bytes),
		.evicted        (evicted),
		.evicted_segment(evicted_segment),
		.failures       (failures),
		.pending        (pending),
		.placed         (placed),
		.oversized      (oversized),
		.refused        (refused),
		.evictions      (evictions)
	);

	// The receiver decides afresh every cycle whether to take a result.
	always @(posedge clk) begin
		out_ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding.",
				cycle_count, pending);
			$display("log_segment_space_allocator_core test failed");
			$finish;
		end
	end

	// Offers one request transaction, idling beforehand when the sender's idle
	// rate says so, and returns at the edge at which it is accepted. Valid is
	// only lowered when a gap is really taken, so back-to-back requests keep it
	// high without a glitch.
	task automatic send_request(input logic [lssa_pkg::KEY_W-1:0] key,
	                            input logic [lssa_pkg::VALUE_W-1:0] value);
		int gap;
		gap = 0;
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		key_length <= key;
		value_length <= value;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		requests_sent++;
	endtask

	// Stops offering requests and waits until every result has come back. The
	// first edge is always taken so that a request accepted at the edge of the
	// call is already counted by the checker.
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		// The block has an input stage and a result register; let it settle completely.
		repeat (2) @(posedge clk);
	endtask

	// Leaves the write enable high; the caller lowers it after its last write.
	task automatic write_register(input lssa_pkg::reg_index_t idx, input int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= lssa_pkg::CFG_W'(val);
		@(posedge clk);
	endtask

	// Reprograms the ring with the block idle. Each write also empties the ring.
	task automatic set_ring(input int unsigned ring_bytes, input int unsigned seg_num);
		drain_results();
		write_register(lssa_pkg::REG_SEGMENT_BYTES, ring_bytes);
		write_register(lssa_pkg::REG_SEGMENT_COUNT, seg_num);
		cfg_we <= 1'b0;
		capacity = (ring_bytes % (2 ** lssa_pkg::CFG_W) > lssa_pkg::MAX_SEGMENT_BYTES) ?
			lssa_pkg::MAX_SEGMENT_BYTES : int'(ring_bytes % (2 ** lssa_pkg::CFG_W));
		settings_applied++;
	endtask

	initial begin
		logic [lssa_pkg::KEY_W-1:0]   key;
		logic [lssa_pkg::VALUE_W-1:0] value;
		int                           pick;
		int                           near_fit;
		int unsigned                  ring_bytes;
		int unsigned                  seg_num;

		// Every input is known from time zero; reset is asserted at the start and then released.
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = lssa_pkg::REG_SEGMENT_BYTES;
		cfg_data = '0;
		in_valid = 1'b0;
		key_length = '0;
		value_length = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		capacity = lssa_pkg::MAX_SEGMENT_BYTES;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, starting from the reset geometry of 64 segments of 1 MiB.
		// Smallest object, longest key, and sizes that need rounding up.
		send_request(8'd0, 21'd0);
		send_request(8'd255, 21'd0);
		send_request(8'd0, 21'd1);
		send_request(8'd1, 21'd2);
		// An object exactly one segment long moves to a fresh segment; one more
		// granule makes it too large.
		send_request(8'd0, 21'd1048556);
		send_request(8'd1, 21'd1048556);
		// Oversized objects whose size does and does not overflow the result field.
		send_request(8'd255, 21'h1FFFFF);
		send_request(8'd0, 21'd2097128);
		send_request(8'd0, 21'd0);

		// A single segment of the smallest size: it fills at once, then refuses.
		set_ring(20, 1);
		send_request(8'd0, 21'd0);
		send_request(8'd0, 21'd0);
		send_request(8'd0, 21'd1);

		// Two tiny segments: once both are full, every further request evicts the head.
		set_ring(20, 2);
		repeat (4) send_request(8'd0, 21'd0);

		// A zero size rejects everything; a zero count behaves as one segment.
		set_ring(0, 0);
		send_request(8'd0, 21'd0);

		// Register values above their limits are clamped to the maximum.
		set_ring(2 ** lssa_pkg::CFG_W - 1, 127);
		send_request(8'd0, 21'd1048556);
		send_request(8'd255, 21'd1048301);
		send_request(8'd0, 21'd0);

		// Random part. Each phase picks a ring geometry and a handshake pattern;
		// most phases use small segments so that the tail wraps and evicts often.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					ring_bytes = $urandom_range(20, 600);
					seg_num = $urandom_range(2, 4);
				end
				1: begin
					ring_bytes = lssa_pkg::MAX_SEGMENT_BYTES;
					seg_num = lssa_pkg::MAX_SEGMENTS;
				end
				2: begin
					ring_bytes = $urandom_range(600, 20000);
					seg_num = $urandom_range(2, 64);
				end
				3: begin
					ring_bytes = 20;
					seg_num = $urandom_range(2, 5);
				end
				4: begin
					ring_bytes = 2 ** lssa_pkg::CFG_W - 1;
					seg_num = 127;
				end
				5: begin
					ring_bytes = $urandom_range(20, 300);
					seg_num = 1;
				end
				6: begin
					ring_bytes = $urandom % (2 ** lssa_pkg::CFG_W);
					seg_num = $urandom_range(0, 127);
				end
				default: begin
					ring_bytes = $urandom_range(20, 3000);
					seg_num = $urandom_range(1, 16);
				end
			endcase
			set_ring(ring_bytes, seg_num);
			case ((p + p / 4) % 4)
				0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1:       begin tx_idle_pct = 62; rx_stall_pct = 0;  end
				2:       begin tx_idle_pct = 0;  rx_stall_pct = 62; end
				default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Halfway through, the sender holds off until the pipeline is empty.
				if (i == PHASE_ITEMS / 2)
					drain_results();
				if ($urandom_range(99) < 30)
					key = lssa_pkg::KEY_W'($urandom_range(0, 255));
				else
					key = lssa_pkg::KEY_W'($urandom_range(0,
						(capacity / 4 > 255) ? 255 : capacity / 4));
				pick = $urandom_range(99);
				if (pick < 8) begin
					// Full-width noise, mostly oversized objects.
					value = lssa_pkg::VALUE_W'($urandom);
				end else if (pick < 22) begin
					// Sizes right at the segment capacity, either side of the rounding.
					near_fit = capacity - lssa_pkg::HEADER_BYTES - int'(key)
						- $urandom_range(0, 4);
					value = (near_fit < 0) ? '0 : lssa_pkg::VALUE_W'(near_fit);
				end else begin
					value = lssa_pkg::VALUE_W'($urandom_range(0,
						capacity / $urandom_range(2, 8)));
				end
				send_request(key, value);
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		$display("Sent %0d requests under %0d ring settings and all four handshake patterns.",
			requests_sent, settings_applied);
		$display("Results: %0d placed (%0d with eviction), %0d oversized, %0d refused for space.",
			placed, evictions, oversized, refused);
		if (failures == 0)
			$display("log_segment_space_allocator_core test passed");
		else
			$display("log_segment_space_allocator_core test failed");
		$finish;
	end

endmodule
